>>> src/assert_macros.svh
// Assertion macros used by the top level of the tile text parser.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Expression must never hold.
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

>>> src/cdtfp_pkg.sv
// Package for the tile text parser: widths, character codes, limits and the
// event and result records. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdtfp_pkg;

    localparam int TILE_VALUES     = 65536;
    localparam int FRAC_DIGITS     = 2;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int MAG_CAP   = 10 ** (FRAC_DIGITS + 4);
    localparam int MAG_W     = $clog2(MAG_CAP + 1);
    localparam int FDS_W     = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
    localparam int CENTI_MAX = 1000000;
    localparam int CENTI_W   = 20;
    localparam int ELEV_W    = 21;
    localparam int INDEX_W   = 16;
    localparam int COUNT_W   = 17;
    localparam int COUNT_MAX = 131071;

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic               has_value;
        logic               has_status;
        logic               seen_digit;
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
        logic [INDEX_W-1:0] index;
        logic               tile_ok;
    } evt_t;

    typedef struct packed {
        logic                      kind;
        logic signed [ELEV_W-1:0]  elevation_centi;
        logic [INDEX_W-1:0]        value_index;
        logic                      tile_ok;
        logic                      last;
    } res_t;

endpackage

`default_nettype wire

>>> src/csv_decimal_to_fixed_tile_parser_unit.sv
// Top level of the tile text parser: front end, event queue, back end and
// result queue. Uses cdtfp_pkg, cdtfp_front, cdtfp_fifo, cdtfp_back.
//
//   channel  handshake     payload
//   input    push / full   text_byte, is_end
//   result   pop / empty   kind, elevation_centi, value_index, tile_ok, last
//
// One byte per cycle in while full is low; one result per cycle out while
// empty is low. A tile end with a pending token gives two results and holds
// the back end until both are pushed; events and results are registered in their queues.
// Reset clears all token state, the value count and both queues.
// full rises when the event queue is full; a stalled pop backs up through it.
`timescale 1ns / 1ps
`default_nettype none

module csv_decimal_to_fixed_tile_parser_unit import cdtfp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [7:0]          text_byte,
    input  wire logic                is_end,
    input  wire logic                pop,
    output logic                     empty,
    output logic                     kind,
    output logic signed [ELEV_W-1:0] elevation_centi,
    output logic [INDEX_W-1:0]       value_index,
    output logic                     tile_ok,
    output logic                     last
);

`include "assert_macros.svh"

    evt_t                 evt_in;
    evt_t                 evt_head;
    logic [$bits(evt_t)-1:0] evt_rdata;
    logic                 evt_push;
    logic                 evt_full;
    logic                 evt_pop;
    logic                 evt_empty;
    res_t                 res_in;
    res_t                 res_head;
    logic [$bits(res_t)-1:0] res_rdata;
    logic                 res_push;
    logic                 res_full;

    cdtfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .is_end    (is_end),
        .evt_full  (evt_full),
        .evt_push  (evt_push),
        .evt_data  (evt_in)
    );

    cdtfp_fifo #(
        .W     ($bits(evt_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_evt_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (evt_push),
        .wdata (evt_in),
        .full  (evt_full),
        .pop   (evt_pop),
        .rdata (evt_rdata),
        .empty (evt_empty)
    );

    assign evt_head = evt_t'(evt_rdata);

    cdtfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_data  (evt_head),
        .evt_empty (evt_empty),
        .evt_pop   (evt_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    cdtfp_fifo #(
        .W     ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_head        = res_t'(res_rdata);
    assign full            = evt_full;
    assign kind            = res_head.kind;
    assign elevation_centi = res_head.elevation_centi;
    assign value_index     = res_head.value_index;
    assign tile_ok         = res_head.tile_ok;
    assign last            = res_head.last;

    `ASSERT_IMPLIES(a_status_fields, !empty && kind == KIND_STATUS,
        elevation_centi == '0 && value_index == '0 && last)
    `ASSERT_IMPLIES(a_value_range, !empty && kind == KIND_VALUE,
        elevation_centi <= ELEV_W'(CENTI_MAX) && elevation_centi >= -ELEV_W'(CENTI_MAX)
        && !tile_ok)
    `ASSERT_NEVER(a_evt_pop_empty, evt_pop && evt_empty)
    `ASSERT_IMPLIES(a_split_event, u_back.value_done_next && res_push,
        res_in.kind == KIND_VALUE && !res_in.last)

endmodule

`default_nettype wire

>>> src/cdtfp_fifo.sv
// Small register queue, used between the front and back and at the output.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cdtfp_fifo #(
    parameter int W     = 1,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/cdtfp_front.sv
// Front end: takes text bytes, tracks token state and value count, and
// issues one event per value or tile end. Uses cdtfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdtfp_front import cdtfp_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] text_byte,
    input  wire logic       is_end,
    input  wire logic       evt_full,
    output logic            evt_push,
    output evt_t            evt_data
);

    logic [MAG_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               nonempty_reg, nonempty_next;
    logic               started_reg, started_next;
    logic               seen_reg, seen_next;
    logic               in_frac_reg, in_frac_next;
    logic [FDS_W-1:0]   fds_reg, fds_next;
    logic               stopped_reg, stopped_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               in_fire;
    logic               is_digit;
    logic               is_blank;
    logic               is_sign;
    logic               take;
    logic [MAG_W+3:0]   acc_ext;
    logic [MAG_W+3:0]   acc_sum;
    logic [MAG_W-1:0]   acc_add;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_after;

    assign in_fire  = push && !evt_full;
    assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign is_blank = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB)
                   || (text_byte == CHAR_VT) || (text_byte == CHAR_FF)
                   || (text_byte == CHAR_CR);
    assign is_sign  = (text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS);

    assign acc_ext   = (MAG_W + 4)'(acc_reg);
    assign acc_sum   = (acc_ext << 3) + (acc_ext << 1)
                     + (MAG_W + 4)'(text_byte[3:0] - CHAR_ZERO[3:0]);
    assign acc_add   = (acc_sum > (MAG_W + 4)'(MAG_CAP)) ? MAG_W'(MAG_CAP)
                                                        : acc_sum[MAG_W-1:0];
    assign count_inc = (count_reg == COUNT_W'(COUNT_MAX)) ? count_reg
                                                          : count_reg + 1'b1;

    always_comb
    begin
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        nonempty_next = nonempty_reg;
        started_next  = started_reg;
        seen_next     = seen_reg;
        in_frac_next  = in_frac_reg;
        fds_next      = fds_reg;
        stopped_next  = stopped_reg;
        count_next    = count_reg;
        count_after   = nonempty_reg ? count_inc : count_reg;
        take          = 1'b0;
        evt_push      = 1'b0;

        evt_data.has_value  = 1'b0;
        evt_data.has_status = 1'b0;
        evt_data.seen_digit = seen_reg;
        evt_data.negative   = neg_reg;
        evt_data.magnitude  = acc_reg;
        evt_data.index      = count_reg[INDEX_W-1:0];
        evt_data.tile_ok    = (count_after == COUNT_W'(TILE_VALUES));

        if (in_fire)
        begin
            if (is_end || text_byte == CHAR_COMMA || text_byte == CHAR_NEWLINE)
            begin
                evt_data.has_value  = nonempty_reg || (!is_end && text_byte == CHAR_COMMA);
                evt_data.has_status = is_end;
                evt_push            = evt_data.has_value || is_end;
                count_next          = is_end ? '0
                                    : (evt_data.has_value ? count_inc : count_reg);
                acc_next      = '0;
                neg_next      = 1'b0;
                nonempty_next = 1'b0;
                started_next  = 1'b0;
                seen_next     = 1'b0;
                in_frac_next  = 1'b0;
                fds_next      = '0;
                stopped_next  = 1'b0;
            end
            else
            begin
                nonempty_next = 1'b1;
                if (!stopped_reg)
                begin
                    if (started_reg)
                    begin
                        take = 1'b1;
                    end
                    else if (is_blank)
                    begin
                        take = 1'b0;
                    end
                    else if (is_sign)
                    begin
                        started_next = 1'b1;
                        neg_next     = (text_byte == CHAR_MINUS);
                    end
                    else if (!is_digit && text_byte != CHAR_DOT)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        started_next = 1'b1;
                        take         = 1'b1;
                    end

                    if (take)
                    begin
                        if (is_digit)
                        begin
                            seen_next = 1'b1;
                            if (!in_frac_reg)
                            begin
                                acc_next = acc_add;
                            end
                            else if (fds_reg < FDS_W'(FRAC_DIGITS))
                            begin
                                acc_next = acc_add;
                                fds_next = fds_reg + 1'b1;
                            end
                        end
                        else if (text_byte == CHAR_DOT && !in_frac_reg)
                        begin
                            in_frac_next = 1'b1;
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
            started_reg  <= 1'b0;
            seen_reg     <= 1'b0;
            in_frac_reg  <= 1'b0;
            fds_reg      <= '0;
            stopped_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            acc_reg      <= acc_next;
            neg_reg      <= neg_next;
            nonempty_reg <= nonempty_next;
            started_reg  <= started_next;
            seen_reg     <= seen_next;
            in_frac_reg  <= in_frac_next;
            fds_reg      <= fds_next;
            stopped_reg  <= stopped_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/cdtfp_back.sv
// Back end: turns each event into one or two result records, scaling the
// magnitude to centimetres with saturation. Uses cdtfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdtfp_back import cdtfp_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  evt_t      evt_data,
    input  wire logic evt_empty,
    output logic      evt_pop,
    input  wire logic res_full,
    output logic      res_push,
    output res_t      res_data
);

    localparam int PROD_W    = MAG_W + 28;
    localparam int UP_SCALE  = (FRAC_DIGITS <= 2) ? 10 ** (2 - FRAC_DIGITS) : 1;
    localparam int RECIP_10  = 13421773;
    localparam int RECIP_SH  = 27;

    function automatic logic [CENTI_W-1:0] to_centi(input logic [MAG_W-1:0] mag);
        logic [PROD_W-1:0] prod;
        if (FRAC_DIGITS <= 2)
        begin
            prod = PROD_W'(mag) * PROD_W'(UP_SCALE);
        end
        else
        begin
            prod = (PROD_W'(mag) * PROD_W'(RECIP_10)) >> RECIP_SH;
        end
        if (prod > PROD_W'(CENTI_MAX))
        begin
            prod = PROD_W'(CENTI_MAX);
        end
        return prod[CENTI_W-1:0];
    endfunction

    logic                     value_done_reg, value_done_next;
    logic                     value_phase;
    logic [CENTI_W-1:0]       centi;
    logic signed [ELEV_W-1:0] centi_ext;

    assign value_phase = evt_data.has_value && !value_done_reg;
    assign centi       = evt_data.seen_digit ? to_centi(evt_data.magnitude) : '0;
    assign centi_ext   = ELEV_W'(centi);
    assign res_push    = !evt_empty && !res_full;
    assign evt_pop     = res_push && !(value_phase && evt_data.has_status);

    always_comb
    begin
        res_data.kind            = value_phase ? KIND_VALUE : KIND_STATUS;
        res_data.elevation_centi = !value_phase ? '0
                                 : (evt_data.negative ? -centi_ext : centi_ext);
        res_data.value_index     = value_phase ? evt_data.index : '0;
        res_data.tile_ok         = value_phase ? 1'b0 : evt_data.tile_ok;
        res_data.last            = value_phase ? !evt_data.has_status : 1'b1;

        value_done_next = value_done_reg;
        if (res_push)
        begin
            value_done_next = value_phase && evt_data.has_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_done_reg <= 1'b0;
        end
        else
        begin
            value_done_reg <= value_done_next;
        end
    end

endmodule

`default_nettype wire

>>> test/csv_decimal_to_fixed_tile_parser_unit_tb.sv
// Self-checking testbench for csv_decimal_to_fixed_tile_parser_unit: directed text,
// then random token streams with idling on both sides.
// Depends on cdtfp_pkg and the parser RTL.
`timescale 1ns / 1ps

module csv_decimal_to_fixed_tile_parser_unit_tb import cdtfp_pkg::*; ();

    localparam int FRAC_SCALE = 10 ** FRAC_DIGITS;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [7:0]               text_byte = 8'h00;
    logic                     is_end = 1'b0;
    logic                     pop = 1'b0;
    logic                     empty;
    logic                     kind;
    logic signed [ELEV_W-1:0] elevation_centi;
    logic [INDEX_W-1:0]       value_index;
    logic                     tile_ok;
    logic                     last;

    // shadow parser state
    logic [MAG_W-1:0]   acc_mag;
    logic               acc_neg;
    logic               tok_nonempty;
    logic               num_started;
    logic               digit_seen;
    logic               frac_mode;
    logic [FDS_W-1:0]   frac_count;
    logic               tok_stopped;
    logic [COUNT_W-1:0] tile_count;

    res_t expected_results[$];
    res_t head_result;
    int   fail_count = 0;
    int   byte_count = 0;
    int   stall_left = 0;
    bit   idle_on = 1'b1;

    logic [7:0] blank_chars[5] = '{CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_CR};

    csv_decimal_to_fixed_tile_parser_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .text_byte       (text_byte),
        .is_end          (is_end),
        .pop             (pop),
        .empty           (empty),
        .kind            (kind),
        .elevation_centi (elevation_centi),
        .value_index     (value_index),
        .tile_ok         (tile_ok),
        .last            (last)
    );

    always #10 clk = ~clk;

    function automatic void clear_token();
        acc_mag      = '0;
        acc_neg      = 1'b0;
        tok_nonempty = 1'b0;
        num_started  = 1'b0;
        digit_seen   = 1'b0;
        frac_mode    = 1'b0;
        frac_count   = '0;
        tok_stopped  = 1'b0;
    endfunction

    function automatic void accumulate_digit(input logic [7:0] c);
        longint v;
        v = longint'(acc_mag) * 10 + longint'(c - CHAR_ZERO);
        if (v > MAG_CAP)
            v = MAG_CAP;
        acc_mag = MAG_W'(v);
    endfunction

    function automatic void queue_expected(input res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void emit_elevation(input logic is_last);
        res_t   r;
        longint mag;
        mag = 0;
        if (digit_seen)
        begin
            mag = longint'(acc_mag) * 100 / FRAC_SCALE;
            if (mag > CENTI_MAX)
                mag = CENTI_MAX;
        end
        r.kind            = KIND_VALUE;
        r.elevation_centi = acc_neg ? ELEV_W'(-mag) : ELEV_W'(mag);
        r.value_index     = tile_count[INDEX_W-1:0];
        r.tile_ok         = 1'b0;
        r.last            = is_last;
        queue_expected(r);
        if (tile_count < COUNT_MAX)
            tile_count = tile_count + 1'b1;
        clear_token();
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
        tok_nonempty = 1'b1;
        if (tok_stopped)
            return;
        if (!num_started)
        begin
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF || c == CHAR_CR)
                return;
            if (c == CHAR_PLUS || c == CHAR_MINUS)
            begin
                num_started = 1'b1;
                acc_neg     = (c == CHAR_MINUS);
                return;
            end
            if (!is_digit && c != CHAR_DOT)
            begin
                tok_stopped = 1'b1;
                return;
            end
            num_started = 1'b1;
        end
        if (is_digit)
        begin
            digit_seen = 1'b1;
            if (!frac_mode)
                accumulate_digit(c);
            else if (frac_count < FRAC_DIGITS)
            begin
                accumulate_digit(c);
                frac_count = frac_count + 1'b1;
            end
        end
        else if (c == CHAR_DOT && !frac_mode)
            frac_mode = 1'b1;
        else
            tok_stopped = 1'b1;
    endfunction

    function automatic void parse_step(input logic [7:0] c, input logic end_flag);
        res_t r;
        if (end_flag)
        begin
            if (tok_nonempty)
                emit_elevation(1'b0);
            r.kind            = KIND_STATUS;
            r.elevation_centi = '0;
            r.value_index     = '0;
            r.tile_ok         = (tile_count == TILE_VALUES);
            r.last            = 1'b1;
            queue_expected(r);
            clear_token();
            tile_count = '0;
        end
        else if (c == CHAR_COMMA)
            emit_elevation(1'b1);
        else if (c == CHAR_NEWLINE)
        begin
            if (tok_nonempty)
                emit_elevation(1'b1);
            clear_token();
        end
        else
            scan_char(c);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] c, input logic end_flag);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push      <= 1'b1;
        text_byte <= c;
        is_end    <= end_flag;
        @(posedge clk);
        while (full)
            @(posedge clk);
        parse_step(c, end_flag);
        byte_count++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_tile_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transfer: kind %0d elevation_centi %0d value_index %0d",
                       kind, elevation_centi, value_index);
                fail_count++;
            end
            else
            begin
                head_result = expected_results.pop_front();
                if (kind !== head_result.kind)
                begin
                    $error("kind: expected %0d, got %0d", head_result.kind, kind);
                    fail_count++;
                end
                if (elevation_centi !== head_result.elevation_centi)
                begin
                    $error("elevation_centi: expected %0d, got %0d",
                           head_result.elevation_centi, elevation_centi);
                    fail_count++;
                end
                if (value_index !== head_result.value_index)
                begin
                    $error("value_index: expected %0d, got %0d",
                           head_result.value_index, value_index);
                    fail_count++;
                end
                if (tile_ok !== head_result.tile_ok)
                begin
                    $error("tile_ok: expected %0d, got %0d", head_result.tile_ok, tile_ok);
                    fail_count++;
                end
                if (last !== head_result.last)
                begin
                    $error("last: expected %0d, got %0d", head_result.last, last);
                    fail_count++;
                end
            end
        end
    end

    // sign, blanks, truncation, stop characters, empty tokens, saturation, end handling
    task automatic test_number_syntax();
        send_text(" +12.345e,");
        send_text("-0\n");
        send_text("\n,");
        send_text("9999999");
        send_byte(8'h00, 1'b0);
        send_text(",-.5");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic send_random_token();
        int n;
        int sel;
        n = $urandom_range(0, 2);
        repeat (n)
            send_byte(blank_chars[$urandom_range(0, 4)], 1'b0);
        sel = $urandom_range(0, 3);
        if (sel == 0)
            send_byte(CHAR_MINUS, 1'b0);
        else if (sel == 1)
            send_byte(CHAR_PLUS, 1'b0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 4);
        repeat (n)
            send_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)), 1'b0);
        if ($urandom_range(0, 1) == 0)
        begin
            send_byte(CHAR_DOT, 1'b0);
            n = $urandom_range(0, 5);
            repeat (n)
                send_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)), 1'b0);
        end
        if ($urandom_range(0, 7) == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        sel = $urandom_range(0, 19);
        if (sel < 14)
            send_byte(CHAR_COMMA, 1'b0);
        else if (sel < 19)
            send_byte(CHAR_NEWLINE, 1'b0);
        else
            send_tile_end();
    endtask

    task automatic test_random_text();
        int start;
        int sel;
        start = byte_count;
        while (byte_count - start < 800)
        begin
            if (byte_count - start > 650)
                idle_on = 1'b0;
            sel = $urandom_range(0, 99);
            if (sel < 10)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            else if (sel < 13)
                send_tile_end();
            else
                send_random_token();
        end
        send_tile_end();
    endtask

    initial
    begin
        clear_token();
        tile_count = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_number_syntax();
        test_random_text();

        push <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
